FILE: src/c2d_pkg.sv
// Shared constants and types for the 3x3 integer convolution block.
package c2d_pkg;

  localparam int C2D_MAX_LINE = 1024;
  localparam int KSIZE        = 3;
  localparam int TAPS         = KSIZE * KSIZE;
  localparam int PIX_W        = 32;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int CNT_W        = 13;
  localparam int MAX_ROWS     = 4096;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH  = 2'd0,
    REG_OUT_HEIGHT = 2'd1
  } c2d_reg_t;

  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } c2d_meta_t;

endpackage

FILE: src/conv2d_3x3_int32_top.sv
// Top level of the streaming 3x3 integer convolution with two line stores.
//
// Usage: first load the nine weights with requests of mode 0 (slot = row * 3 + column),
// then stream the image of out_height+2 rows by out_width+2 columns in row-major order
// with requests of mode 1. Every pixel whose row and column are both at least 2 gives
// one result: the weighted window sum wrapped to 32 bits, its output row and column,
// and frame_last on the final result of the image. Counters wrap for the next image.
// The user must write the size registers through the cfg channel only while idle; the
// block does not enforce it. Throughput is one request per cycle while in_ready is
// high; the line stores are read when a pixel is taken and written back from the next
// stage, so consecutive pixels never touch the same entry. An accepted pixel
// passes through line store read, nine multiplies, partial sums and final sum into
// the output register. A two-entry output buffer absorbs a stalled receiver; in_ready
// falls only while its second entry is occupied, and the whole pipeline then holds.
// Reset clears the weights, the window, the position counters and the output buffer,
// and sets both size registers to 1. The line stores are not cleared.
module conv2d_3x3_int32_top
  import c2d_pkg::*;
#(
  parameter int MAX_LINE = C2D_MAX_LINE
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic [3:0]              weight_index,
  input  logic signed [PIX_W-1:0] weight_value,
  input  logic signed [PIX_W-1:0] pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] sum,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic                    frame_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_LINE);

  logic [COL_W-1:0] out_width;
  logic [ROW_W-1:0] out_height;
  logic [PIX_W-1:0] weights [TAPS];
  logic [PIX_W-1:0] window [6];
  logic [ROW_W-1:0] in_row;
  logic [CW-1:0]    in_col;

  logic en, accept, pix_accept;
  logic [CNT_W-1:0] line_len, frame_len, row_off, col_off;
  logic last_col, last_row;

  logic             s1_valid, s1_emit;
  c2d_meta_t        s1_meta;
  logic [PIX_W-1:0] s1_low;
  logic [CW-1:0]    s1_idx;
  logic [PIX_W-1:0] up, mid;
  logic [PIX_W-1:0] tap [TAPS];
  logic             line_we;

  logic             s2_valid;
  c2d_meta_t        s2_meta;
  logic [PIX_W-1:0] prod [TAPS];

  logic             s3_valid;
  c2d_meta_t        s3_meta;
  logic [PIX_W-1:0] part [KSIZE];

  logic             push;
  logic [PIX_W-1:0] total;
  logic             skid_valid;
  logic [PIX_W-1:0] skid_sum;
  c2d_meta_t        skid_meta;

  assign en         = !skid_valid;
  assign in_ready   = en;
  assign accept     = in_valid && in_ready;
  assign pix_accept = accept && (mode == MODE_PIXEL);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= COL_W'(1);
      out_height <= ROW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUT_WIDTH:  out_width  <= cfg_data[COL_W-1:0];
        REG_OUT_HEIGHT: out_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        weights[k] <= '0;
      end
    end else if (accept && (mode == MODE_WEIGHT) && (weight_index < 4'(TAPS))) begin
      weights[weight_index] <= weight_value;
    end
  end

  always_comb begin
    line_len  = CNT_W'(out_width) + CNT_W'(2);
    if (line_len > CNT_W'(MAX_LINE)) begin
      line_len = CNT_W'(MAX_LINE);
    end
    frame_len = CNT_W'(out_height) + CNT_W'(2);
    if (frame_len > CNT_W'(MAX_ROWS)) begin
      frame_len = CNT_W'(MAX_ROWS);
    end
    last_col = (CNT_W'(in_col) + CNT_W'(1)) >= line_len;
    last_row = (CNT_W'(in_row) + CNT_W'(1)) >= frame_len;
    row_off  = CNT_W'(in_row) - CNT_W'(2);
    col_off  = CNT_W'(in_col) - CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (pix_accept) begin
      if (last_col) begin
        in_col <= '0;
        in_row <= last_row ? '0 : in_row + ROW_W'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  c2d_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_upper (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_idx),
    .wdata (mid),
    .re    (pix_accept),
    .raddr (in_col),
    .rdata (up)
  );

  c2d_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_middle (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_idx),
    .wdata (s1_low),
    .re    (pix_accept),
    .raddr (in_col),
    .rdata (mid)
  );

  assign line_we = s1_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pix_accept) begin
      s1_emit       <= (in_row >= ROW_W'(2)) && (CNT_W'(in_col) >= CNT_W'(2));
      s1_meta.row   <= row_off[ROW_W-1:0];
      s1_meta.col   <= col_off[COL_W-1:0];
      s1_meta.last  <= last_col && last_row;
      s1_low        <= pixel;
      s1_idx        <= in_col;
    end
  end

  always_comb begin
    tap[0] = window[0];
    tap[3] = window[1];
    tap[6] = window[2];
    tap[1] = window[3];
    tap[4] = window[4];
    tap[7] = window[5];
    tap[2] = up;
    tap[5] = mid;
    tap[8] = s1_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        window[k] <= '0;
      end
    end else if (line_we) begin
      window[0] <= window[3];
      window[1] <= window[4];
      window[2] <= window[5];
      window[3] <= up;
      window[4] <= mid;
      window[5] <= s1_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TAPS; k++) begin
        prod[k] <= weights[k] * tap[k];
      end
      s2_meta <= s1_meta;
      for (int i = 0; i < KSIZE; i++) begin
        part[i] <= prod[3*i] + prod[3*i+1] + prod[3*i+2];
      end
      s3_meta <= s2_meta;
    end
  end

  assign total = part[0] + part[1] + part[2];
  assign push  = s3_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        sum        <= skid_sum;
        out_row    <= skid_meta.row;
        out_col    <= skid_meta.col;
        frame_last <= skid_meta.last;
      end else if (push) begin
        sum        <= total;
        out_row    <= s3_meta.row;
        out_col    <= s3_meta.col;
        frame_last <= s3_meta.last;
      end
    end else if (push) begin
      skid_sum  <= total;
      skid_meta <= s3_meta;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("output buffer second entry held without a first");

  a_no_line_collision: assert property (@(posedge clk) disable iff (rst)
    !(pix_accept && line_we && (in_col == s1_idx)))
    else $error("line store read and write back hit the same entry");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without a stalled receiver");
`endif

endmodule

FILE: src/c2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
